>>> sv/sadal_pkg.sv
// shared types and constants for the slot allocator with dense active list
// used by sadal_ctrl, sadal_dp and the top level (sadal_ram does not import it); no dependencies
package sadal_pkg;

    localparam int SLOTS  = 2048;
    localparam int SLOT_W = 11;
    localparam int CNT_W  = 12;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_out;
        logic [CNT_W-1:0]  active_total;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic             out_free;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] hwm;
    } t_dp_stat;

endpackage

>>> sv/sadal_ram.sv
// generic single write port, single registered read port ram
// no package dependencies
module sadal_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/sadal_ctrl.sv
// controller fsm: accepts a transaction, then commits it once the output register is free
// depends on sadal_pkg
module sadal_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sadal_pkg::t_dp_stat i_stat,
    output sadal_pkg::t_ctl_cmd o_cmd
);
    import sadal_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/sadal_dp.sv
// datapath: free list, active list, position map, active flags, counters and output register
// depends on sadal_pkg and sadal_ram
module sadal_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sadal_pkg::t_ctl_cmd  i_cmd,
    input  sadal_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sadal_pkg::t_out_item o_out_item,
    output sadal_pkg::t_dp_stat  o_stat
);
    import sadal_pkg::*;

    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    // captured transaction
    logic [1:0]        r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_pos;

    // control state; r_hwm counts slots ever taken from the untouched region
    logic [CNT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_hwm, n_hwm;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] slot_ext;
    logic [CNT_W-1:0] pos_ext;
    logic             full;
    logic             rel_ok;
    logic             rd_ok;

    // memory ports
    logic [CNT_W-1:0]  nf_rdata;
    logic              nf_we;
    logic [SLOT_W-1:0] nf_waddr;
    logic [CNT_W-1:0]  nf_wdata;

    logic [SLOT_W-1:0] al_rdata;
    logic [SLOT_W-1:0] al_raddr;
    logic              al_we;
    logic [SLOT_W-1:0] al_waddr;
    logic [SLOT_W-1:0] al_wdata;

    logic [CNT_W-1:0]  lp_rdata;
    logic              lp_we;
    logic [SLOT_W-1:0] lp_waddr;
    logic [CNT_W-1:0]  lp_wdata;

    logic              act_rdata;
    logic              act_we;
    logic [SLOT_W-1:0] act_waddr;
    logic              act_wdata;

    assign cnt_m1   = r_count - CNT_W'(1);
    assign al_raddr = (i_in_item.operation == OP_READ) ? i_in_item.position
                                                       : cnt_m1[SLOT_W-1:0];

    sadal_ram #(.DEPTH(SLOTS), .WIDTH(CNT_W)) u_next_free (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && nf_we),
        .i_waddr (nf_waddr),
        .i_wdata (nf_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (r_head[SLOT_W-1:0]),
        .o_rdata (nf_rdata)
    );

    sadal_ram #(.DEPTH(SLOTS), .WIDTH(SLOT_W)) u_active_list (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && al_we),
        .i_waddr (al_waddr),
        .i_wdata (al_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (al_raddr),
        .o_rdata (al_rdata)
    );

    sadal_ram #(.DEPTH(SLOTS), .WIDTH(CNT_W)) u_list_pos (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && lp_we),
        .i_waddr (lp_waddr),
        .i_wdata (lp_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (i_in_item.slot),
        .o_rdata (lp_rdata)
    );

    sadal_ram #(.DEPTH(SLOTS), .WIDTH(1)) u_active_flag (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && act_we),
        .i_waddr (act_waddr),
        .i_wdata (act_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (i_in_item.slot),
        .o_rdata (act_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_in_item.operation;
            r_slot <= i_in_item.slot;
            r_pos  <= i_in_item.position;
        end
    end

    assign slot_ext = {1'b0, r_slot};
    assign pos_ext  = {1'b0, r_pos};
    assign full     = (r_head >= SLOTS_C) || (r_count >= SLOTS_C);
    // slots at or above the high-water mark were never allocated, so their flag is stale
    assign rel_ok   = (slot_ext < SLOTS_C) && (slot_ext < r_hwm) && act_rdata
                      && (lp_rdata < r_count);
    assign rd_ok    = (pos_ext < r_count) && (pos_ext < SLOTS_C);

    always_comb begin
        n_head    = r_head;
        n_hwm     = r_hwm;
        n_count   = r_count;
        n_out     = '{status: ST_BAD, slot_out: '0, active_total: r_count};
        nf_we     = 1'b0;
        nf_waddr  = r_slot;
        nf_wdata  = r_head;
        al_we     = 1'b0;
        al_waddr  = lp_rdata[SLOT_W-1:0];
        al_wdata  = al_rdata;
        lp_we     = 1'b0;
        lp_waddr  = al_rdata;
        lp_wdata  = lp_rdata;
        act_we    = 1'b0;
        act_waddr = r_slot;
        act_wdata = 1'b0;
        unique case (r_op)
            OP_ALLOC: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_out   = '{status: ST_OK, slot_out: r_head[SLOT_W-1:0],
                                active_total: r_count + CNT_W'(1)};
                    // untouched region: the link is simply the next index
                    if (r_head == r_hwm) begin
                        n_head = r_hwm + CNT_W'(1);
                        n_hwm  = r_hwm + CNT_W'(1);
                    end else begin
                        n_head = nf_rdata;
                    end
                    al_we     = 1'b1;
                    al_waddr  = r_count[SLOT_W-1:0];
                    al_wdata  = r_head[SLOT_W-1:0];
                    lp_we     = 1'b1;
                    lp_waddr  = r_head[SLOT_W-1:0];
                    lp_wdata  = r_count;
                    act_we    = 1'b1;
                    act_waddr = r_head[SLOT_W-1:0];
                    act_wdata = 1'b1;
                end
            end
            OP_RELEASE: begin
                if (rel_ok) begin
                    // move the last entry into the freed position
                    al_we   = 1'b1;
                    lp_we   = 1'b1;
                    act_we  = 1'b1;
                    nf_we   = 1'b1;
                    n_head  = slot_ext;
                    n_count = cnt_m1;
                    n_out   = '{status: ST_OK, slot_out: r_slot, active_total: cnt_m1};
                end
            end
            OP_READ: begin
                if (rd_ok) begin
                    n_out = '{status: ST_OK, slot_out: al_rdata, active_total: r_count};
                end
            end
            default: begin
                n_out.status = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_hwm       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_head      <= n_head;
                r_hwm       <= n_hwm;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.count    = r_count;
    assign o_stat.hwm      = r_hwm;

endmodule

>>> sv/slot_allocator_dense_active_list_unit.sv
// top level of the slot allocator with dense active list
// depends on sadal_pkg, sadal_ctrl, sadal_dp (which holds the sadal_ram instances)
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_ready  | i_in_item  (operation, slot, position)
//   out     | output    | o_out_valid / i_out_ready| o_out_item (status, slot_out, active_total)
//
// in each transaction the accept edge reads all four memories; the commit edge, once the
// output register is free, commits the memory writes and loads the output register.
// a new transaction is taken while the previous result still waits in the output register.
// commit stalls only while the output register is full and not being taken.
// reset is synchronous; no clearing pass, the memories are tracked by a high-water mark.
module slot_allocator_dense_active_list_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sadal_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sadal_pkg::t_out_item o_out_item
);
    import sadal_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    sadal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sadal_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_stat      (stat)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("transaction accepted while another is in flight");

    a_count_le_hwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= stat.hwm)
        else $error("active count above high-water mark");

    a_hwm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.hwm <= CNT_W'(SLOTS))
        else $error("high-water mark beyond pool size");

    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.commit))
        else $error("result shown without a commit");

endmodule
